@@ rtl/core/assert_macros.svh @@
// Assertion helper macros, empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ rtl/core/swq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swq_pkg
// Types and constants shared by the semaphore wait queue table.
// ----------------------------------------------------------------------------
package swq_pkg;
   localparam int PoolSizeDefault = 32;
   localparam int KeyBitsDefault  = 32;
   localparam int ProcCount       = 32;
   localparam int ProcBits        = 5;

   typedef enum logic [1:0] {
      OP_BLOCK   = 2'd0,
      OP_UNBLOCK = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_PEEK    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BLOCKED   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] key;
      logic [4:0]  process_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] result_process;
      logic       none_active;
   } rsp_type;
endpackage

@@ rtl/core/swq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swq_front
// Input stage and two-entry command queue feeding the execution engine.
// ----------------------------------------------------------------------------
module swq_front import swq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_take,
   output req_type cmd_data
);
   req_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) begin
         q_ff[wr_ff] <= req_data;
      end
   end
endmodule

@@ rtl/core/swq_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swq_back
// Execution engine: key search over the pool, then a linked-list update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module swq_back import swq_pkg::*; #(
   parameter int POOL_SIZE = PoolSizeDefault,
   parameter int KEY_BITS  = KeyBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_take,
   input  req_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int DB = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;

   typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_READ, S_EXEC, S_UNLINK, S_OUT} state_type;

   state_type           state_ff;
   logic [KW-1:0]       key_mem [POOL_SIZE];
   logic [ProcBits-1:0] head_mem [POOL_SIZE];
   logic [ProcBits-1:0] tail_mem [POOL_SIZE];
   logic [DB-1:0]       pdesc_ff [ProcCount];
   logic [ProcBits-1:0] next_ff [ProcCount];
   logic [ProcBits-1:0] prev_ff [ProcCount];
   logic [POOL_SIZE-1:0] active_ff;
   logic [ProcCount-1:0] blocked_ff;

   logic [1:0]          op_ff;
   logic [KW-1:0]       key_ff;
   logic [ProcBits-1:0] pid_ff;
   logic                found_ff, free_ok_ff;
   logic [DB-1:0]       d_ff, free_ff;
   logic [ProcBits-1:0] h_ff, t_ff, up_ff;
   logic [1:0]          st_ff;
   logic [ProcBits-1:0] rp_ff;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;

   // Combinational key match and first-free search over the pool.
   logic          hit, fr;
   logic [DB-1:0] hit_d, fr_d;
   always_comb begin
      hit = 1'b0; hit_d = '0; fr = 1'b0; fr_d = '0;
      for (int i = POOL_SIZE - 1; i >= 0; i--) begin
         if (active_ff[i] && key_mem[i] == key_ff) begin
            hit = 1'b1; hit_d = DB'(i);
         end
         if (!active_ff[i]) begin
            fr = 1'b1; fr_d = DB'(i);
         end
      end
   end

   // Outcome of the execute step, held until the response register is free.
   logic [1:0]          exec_status;
   logic [ProcBits-1:0] exec_proc;
   logic                exec_unlink;
   always_comb begin
      exec_status = ST_OK;
      exec_proc   = '0;
      exec_unlink = 1'b0;
      unique case (op_ff)
         OP_BLOCK: begin
            if (blocked_ff[pid_ff]) begin
               exec_status = ST_BLOCKED;
            end else if (!found_ff && !free_ok_ff) begin
               exec_status = ST_NO_FREE;
            end
         end
         OP_REMOVE: begin
            if (!blocked_ff[pid_ff]) begin
               exec_status = ST_NOT_FOUND;
            end else begin
               exec_proc   = pid_ff;
               exec_unlink = 1'b1;
            end
         end
         OP_UNBLOCK, OP_PEEK: begin
            if (!found_ff) begin
               exec_status = ST_NOT_FOUND;
            end else begin
               exec_proc   = h_ff;
               exec_unlink = (op_ff == OP_UNBLOCK);
            end
         end
      endcase
   end

   logic rsp_load, exec_block;
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign exec_block = (state_ff == S_EXEC) && (op_ff == OP_BLOCK) && (exec_status == ST_OK);

   assign cmd_take  = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic [ProcBits-1:0] u;
   logic [DB-1:0]       ud;
   logic                uhead, utail;
   assign u     = up_ff;
   assign ud    = pdesc_ff[u];
   assign uhead = (head_mem[ud] == u);
   assign utail = (tail_mem[ud] == u);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         blocked_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  op_ff    <= cmd_data.operation;
                  key_ff   <= cmd_data.key[KW-1:0];
                  pid_ff   <= cmd_data.process_id;
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               found_ff   <= hit;
               d_ff       <= hit_d;
               free_ok_ff <= fr;
               free_ff    <= fr_d;
               state_ff   <= S_READ;
            end
            S_READ: begin
               h_ff     <= head_mem[d_ff];
               t_ff     <= tail_mem[d_ff];
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               st_ff    <= exec_status;
               rp_ff    <= exec_proc;
               up_ff    <= (op_ff == OP_REMOVE) ? pid_ff : h_ff;
               state_ff <= exec_unlink ? S_UNLINK : S_OUT;
               if (exec_block) begin
                  if (found_ff) begin
                     next_ff[t_ff]      <= pid_ff;
                     prev_ff[pid_ff]    <= t_ff;
                     tail_mem[d_ff]     <= pid_ff;
                     pdesc_ff[pid_ff]   <= d_ff;
                     blocked_ff[pid_ff] <= 1'b1;
                  end else begin
                     active_ff[free_ff] <= 1'b1;
                     key_mem[free_ff]   <= key_ff;
                     head_mem[free_ff]  <= pid_ff;
                     tail_mem[free_ff]  <= pid_ff;
                     pdesc_ff[pid_ff]   <= free_ff;
                     blocked_ff[pid_ff] <= 1'b1;
                  end
               end
            end
            S_UNLINK: begin
               if (uhead && utail) begin
                  active_ff[ud] <= 1'b0;
               end else begin
                  if (uhead) head_mem[ud] <= next_ff[u];
                  else       next_ff[prev_ff[u]] <= next_ff[u];
                  if (utail) tail_mem[ud] <= prev_ff[u];
                  else       prev_ff[next_ff[u]] <= prev_ff[u];
               end
               blocked_ff[u] <= 1'b0;
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_ff.status         <= st_ff;
                  rsp_ff.result_process <= rp_ff;
                  rsp_ff.none_active    <= (active_ff == '0);
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_NEXT(a_out_valid, clock, reset, rsp_load, rsp_valid_ff)
   `ASSERT_IMPLIES(a_take_idle, clock, reset, cmd_take, state_ff == S_IDLE)
   `ASSERT_NEXT(a_block_ok, clock, reset, exec_block, blocked_ff[pid_ff])
   `ASSERT_NEXT(a_unlink_clears, clock, reset, state_ff == S_UNLINK, !blocked_ff[$past(up_ff)])
endmodule

@@ rtl/core/semaphore_wait_queue_table_unit.sv @@
`timescale 1ns / 1ps
// Each request passes the command queue and the engine states idle, search, read,
// execute and output; remove and unblock that find a waiting process also unlink.
// The engine takes a new command only when idle, once the last response is loaded.
// A two-entry command queue takes requests while the engine works.
// Reset (synchronous, active high) frees all descriptors and unblocks all processes.
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table_unit
// Active semaphore list: a pool of keyed descriptors holding FIFOs of
// blocked processes, with block, unblock, remove and peek operations.
// ----------------------------------------------------------------------------
module semaphore_wait_queue_table_unit import swq_pkg::*; #(
   parameter int POOL_SIZE = PoolSizeDefault,
   parameter int KEY_BITS  = KeyBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic    cmd_valid, cmd_take;
   req_type cmd_data;

   // The front queue decouples request beats from the engine.
   swq_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   // The engine runs one command at a time and holds the response register.
   swq_back #(.POOL_SIZE(POOL_SIZE), .KEY_BITS(KEY_BITS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the semaphore wait queue table. A behavioral copy of
// the descriptor pool and process queues predicts every response beat; a
// checker compares each response field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top import swq_pkg::*; ();

   localparam int PoolSlots = 32;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   semaphore_wait_queue_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // Shadow of the descriptor pool and the per-process links.
   logic [31:0] sem_key    [PoolSlots];
   logic        sem_active [PoolSlots];
   logic [4:0]  sem_head   [PoolSlots];
   logic [4:0]  sem_tail   [PoolSlots];
   logic [4:0]  proc_next  [ProcCount];
   logic [4:0]  proc_prev  [ProcCount];
   logic [4:0]  proc_sem   [ProcCount];
   logic        proc_waiting [ProcCount];

   rsp_type pending_rsp[$];
   int      error_count = 0;
   int      rsp_seen = 0;
   int      sent_count = 0;
   logic    stim_done = 1'b0;

   // Small key set so that blocks share queues.
   logic [31:0] key_set[8] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1,
                               32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h7FFF_FFFF};

   function automatic int find_sem(logic [31:0] k);
      for (int d = 0; d < PoolSlots; d++)
         if (sem_active[d] && sem_key[d] == k) return d;
      return -1;
   endfunction

   function automatic logic pool_empty();
      for (int d = 0; d < PoolSlots; d++)
         if (sem_active[d]) return 1'b0;
      return 1'b1;
   endfunction

   // Take a waiting process out of its queue; an emptied descriptor is freed.
   task automatic unlink_waiter(logic [4:0] p);
      int d;
      logic [4:0] nx, pv;
      logic at_head, at_tail;
      d = proc_sem[p];
      nx = proc_next[p];
      pv = proc_prev[p];
      at_head = (sem_head[d] == p);
      at_tail = (sem_tail[d] == p);
      if (at_head && at_tail) begin
         sem_active[d] = 1'b0;
      end else begin
         if (at_head) sem_head[d] = nx;
         else proc_next[pv] = nx;
         if (at_tail) sem_tail[d] = pv;
         else proc_prev[nx] = pv;
      end
      proc_waiting[p] = 1'b0;
   endtask

   task automatic predict_semaphore(req_type r);
      rsp_type e;
      int d;
      e = '0;
      e.status = ST_OK;
      case (op_type'(r.operation))
         OP_BLOCK: begin
            if (proc_waiting[r.process_id]) begin
               e.status = ST_BLOCKED;
            end else begin
               d = find_sem(r.key);
               if (d < 0) begin
                  for (int f = 0; f < PoolSlots; f++)
                     if (!sem_active[f]) begin
                        d = f;
                        break;
                     end
                  if (d >= 0) begin
                     sem_active[d] = 1'b1;
                     sem_key[d] = r.key;
                     sem_head[d] = r.process_id;
                     sem_tail[d] = r.process_id;
                  end
               end else begin
                  proc_next[sem_tail[d]] = r.process_id;
                  proc_prev[r.process_id] = sem_tail[d];
                  sem_tail[d] = r.process_id;
               end
               if (d < 0) begin
                  e.status = ST_NO_FREE;
               end else begin
                  proc_sem[r.process_id] = 5'(d);
                  proc_waiting[r.process_id] = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (!proc_waiting[r.process_id]) begin
               e.status = ST_NOT_FOUND;
            end else begin
               unlink_waiter(r.process_id);
               e.result_process = r.process_id;
            end
         end
         default: begin
            d = find_sem(r.key);
            if (d < 0) begin
               e.status = ST_NOT_FOUND;
            end else begin
               e.result_process = sem_head[d];
               if (r.operation == OP_UNBLOCK) unlink_waiter(sem_head[d]);
            end
         end
      endcase
      e.none_active = pool_empty();
      pending_rsp.push_back(e);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("mismatch on response %0d: %s got %0d expected %0d",
               rsp_seen, what, got, want);
   endtask

   // Send one request beat after a random gap; valid holds until accepted.
   task automatic send_request(op_type op, logic [31:0] k, logic [4:0] p);
      req_type r;
      int gap;
      r.operation = op;
      r.key = k;
      r.process_id = p;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_semaphore(r);
      sent_count++;
      @(negedge clock);
   endtask

   // Response side: random stalls, then check at the accepting edge.
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         stall = $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response beat", 1, 0);
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.status != e.status)
               report_mismatch("status", rsp_data.status, e.status);
            if (rsp_data.result_process != e.result_process)
               report_mismatch("result_process", rsp_data.result_process,
                               e.result_process);
            if (rsp_data.none_active != e.none_active)
               report_mismatch("none_active", rsp_data.none_active, e.none_active);
         end
         rsp_seen++;
      end
   end

   // Extremes of every field and each special case in turn.
   task automatic test_directed();
      send_request(OP_PEEK, 32'h0, 5'd0);             // peek of an unknown key
      send_request(OP_UNBLOCK, 32'hFFFF_FFFF, 5'd31); // unblock of an unknown key
      send_request(OP_REMOVE, 32'h0, 5'd31);          // remove of an idle process
      send_request(OP_BLOCK, 32'hFFFF_FFFF, 5'd31);
      send_request(OP_BLOCK, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_BLOCK, 32'h0, 5'd31);           // already waiting
      send_request(OP_BLOCK, 32'hFFFF_FFFE, 5'd1);    // key differs in one bit
      send_request(OP_PEEK, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_REMOVE, 32'h0, 5'd0);           // remove from the tail
      send_request(OP_UNBLOCK, 32'hFFFF_FFFF, 5'd0);  // queue empties
      send_request(OP_UNBLOCK, 32'hFFFF_FFFE, 5'd0);  // pool is empty again
      // Fill the pool with one process per key, then reuse a freed slot.
      for (int i = 0; i < 32; i++) send_request(OP_BLOCK, 32'h100 + i, 5'(i));
      send_request(OP_REMOVE, 32'h0, 5'd5);
      send_request(OP_BLOCK, 32'hDEAD_BEEF, 5'd5);
      send_request(OP_BLOCK, 32'hCAFE_F00D, 5'd5);    // already waiting, pool full
      for (int i = 0; i < 32; i++) send_request(OP_REMOVE, 32'h0, 5'(i));
   endtask

   // Mostly small key sets so queues grow deep; some fully random keys.
   task automatic test_random(int count);
      logic [31:0] k;
      for (int i = 0; i < count; i++) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom() : key_set[$urandom_range(0, 7)];
         send_request(op_type'($urandom_range(0, 3)), k, 5'($urandom_range(0, 31)));
      end
   endtask

   // Crowd the pool with many distinct keys so it runs full often.
   task automatic test_pool_pressure(int count);
      for (int i = 0; i < count; i++)
         send_request(($urandom_range(0, 2) != 0) ? OP_BLOCK : op_type'($urandom_range(1, 3)),
                      32'($urandom_range(0, 40)), 5'($urandom_range(0, 31)));
   endtask

   initial begin
      for (int i = 0; i < 32; i++) begin
         sem_active[i] = 1'b0;
         proc_waiting[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(900);
      test_pool_pressure(300);
      req_valid <= 1'b0;
      stim_done = 1'b1;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d requests and checked %0d responses, covering a full", sent_count,
               rsp_seen);
      $display("pool, queue removal at head, middle and tail, and unknown keys.");
      if (error_count == 0) begin
         $display("PASS semaphore_wait_queue_table_unit");
      end else begin
         $display("FAIL semaphore_wait_queue_table_unit");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("FAIL semaphore_wait_queue_table_unit");
      $finish;
   end
endmodule

@@ semaphore_wait_queue_table_unit.f @@
+incdir+rtl/core
rtl/core/swq_pkg.sv
rtl/core/swq_front.sv
rtl/core/swq_back.sv
rtl/core/semaphore_wait_queue_table_unit.sv
verif/tb_top.sv
